### rtl/mlfr_pkg.sv
// shared constants and types for the marker length frame receiver
package mlfr_pkg;

   localparam int POS_BITS  = 5;
   localparam int RUN_LEN   = 5;
   localparam int LEN_BYTES = 8;
   localparam int HDR_BYTES = 18;
   localparam int TRL_BYTES = 10;

   localparam logic [7:0] MARK_HDR_OPEN  = 8'h20;
   localparam logic [7:0] MARK_HDR_CLOSE = 8'h21;
   localparam logic [7:0] MARK_TRL_OPEN  = 8'h22;
   localparam logic [7:0] MARK_TRL_CLOSE = 8'h23;

   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_STATUS  = 1'b1;

   localparam logic [2:0] STATUS_GOOD        = 3'd0;
   localparam logic [2:0] STATUS_BAD_MARKER  = 3'd1;
   localparam logic [2:0] STATUS_NONPOSITIVE = 3'd2;
   localparam logic [2:0] STATUS_TOO_LARGE   = 3'd3;
   localparam logic [2:0] STATUS_BAD_TRAILER = 3'd4;

   typedef struct packed {
      logic       valid;
      logic       result_kind;
      logic [7:0] payload_byte;
      logic       payload_last;
      logic [2:0] frame_status;
   } mlfr_result_type;

endpackage

### rtl/mlfr_if.sv
// valid/ready channels for received bytes and for results
interface mlfr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface mlfr_rsp_if;
   logic       valid;
   logic       ready;
   logic       result_kind;
   logic [7:0] payload_byte;
   logic       payload_last;
   logic [2:0] frame_status;

   modport source (output valid, output result_kind, output payload_byte,
                   output payload_last, output frame_status, input ready);
   modport sink (input valid, input result_kind, input payload_byte,
                 input payload_last, input frame_status, output ready);
endinterface

### rtl/mlfr_parse.sv
// framing state machine: header hunt, payload count and trailer check
module mlfr_parse
   import mlfr_pkg::*;
#(
   parameter int LENGTH_BITS = 32
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            step,
   input  logic [7:0]      rx_byte,
   output mlfr_result_type result
);

   typedef enum logic [1:0] {
      PH_HEADER  = 2'd0,
      PH_PAYLOAD = 2'd1,
      PH_TRAILER = 2'd2
   } phase_type;

   localparam logic [63:0] LOW_MASK  = (64'd1 << LENGTH_BITS) - 64'd1;
   localparam logic [63:0] HIGH_MASK = ~LOW_MASK & {1'b0, {63{1'b1}}};

   phase_type               phase_ff, phase_in;
   logic [POS_BITS-1:0]     pos_ff, pos_in;
   logic [LENGTH_BITS-1:0]  len_low_ff, len_low_in;
   logic                    len_over_ff, len_over_in;
   logic                    len_neg_ff, len_neg_in;
   logic [LENGTH_BITS-1:0]  remaining_ff, remaining_in;
   logic                    fault_ff, fault_in;

   logic [POS_BITS-1:0]     len_idx;
   logic [63:0]             byte_word;
   logic [LENGTH_BITS-1:0]  low_now;
   logic                    over_now;
   logic                    neg_now;
   logic                    fault_now;
   logic [7:0]              trl_want;
   logic                    last_now;

   // length byte placed at its little-endian position
   assign len_idx   = pos_ff - POS_BITS'(RUN_LEN);
   assign byte_word = {56'd0, rx_byte} << {len_idx[2:0], 3'b000};
   assign trl_want  = (pos_ff < POS_BITS'(RUN_LEN)) ? MARK_TRL_OPEN : MARK_TRL_CLOSE;
   assign last_now  = remaining_ff <= LENGTH_BITS'(1);

   always_comb begin
      phase_in     = phase_ff;
      pos_in       = pos_ff;
      len_low_in   = len_low_ff;
      len_over_in  = len_over_ff;
      len_neg_in   = len_neg_ff;
      remaining_in = remaining_ff;
      fault_in     = fault_ff;
      result       = '0;
      low_now      = len_low_ff;
      over_now     = len_over_ff;
      neg_now      = len_neg_ff;
      fault_now    = fault_ff;
      if (step) begin
         unique case (phase_ff)
            PH_PAYLOAD: begin
               result.valid        = 1'b1;
               result.result_kind  = KIND_PAYLOAD;
               result.payload_byte = rx_byte;
               result.payload_last = last_now;
               if (last_now) begin
                  remaining_in = '0;
                  phase_in     = PH_TRAILER;
                  pos_in       = '0;
                  fault_in     = 1'b0;
               end else begin
                  remaining_in = remaining_ff - LENGTH_BITS'(1);
               end
            end
            PH_TRAILER: begin
               fault_now = fault_ff | (rx_byte != trl_want);
               if (pos_ff >= POS_BITS'(TRL_BYTES - 1)) begin
                  result.valid        = 1'b1;
                  result.result_kind  = KIND_STATUS;
                  result.frame_status = fault_now ? STATUS_BAD_TRAILER : STATUS_GOOD;
                  phase_in    = PH_HEADER;
                  pos_in      = '0;
                  len_low_in  = '0;
                  len_over_in = 1'b0;
                  len_neg_in  = 1'b0;
                  fault_in    = 1'b0;
               end else begin
                  pos_in   = pos_ff + POS_BITS'(1);
                  fault_in = fault_now;
               end
            end
            default: begin
               // header, also the unused phase code
               if (pos_ff < POS_BITS'(RUN_LEN)) begin
                  fault_now = fault_ff | (rx_byte != MARK_HDR_OPEN);
               end else if (pos_ff < POS_BITS'(RUN_LEN + LEN_BYTES)) begin
                  low_now  = len_low_ff | byte_word[LENGTH_BITS-1:0];
                  over_now = len_over_ff | (|(byte_word & HIGH_MASK));
                  neg_now  = len_neg_ff | byte_word[63];
               end else begin
                  fault_now = fault_ff | (rx_byte != MARK_HDR_CLOSE);
               end
               if (pos_ff >= POS_BITS'(HDR_BYTES - 1)) begin
                  phase_in    = PH_HEADER;
                  pos_in      = '0;
                  len_low_in  = '0;
                  len_over_in = 1'b0;
                  len_neg_in  = 1'b0;
                  fault_in    = 1'b0;
                  result.result_kind = KIND_STATUS;
                  if (fault_now) begin
                     result.valid        = 1'b1;
                     result.frame_status = STATUS_BAD_MARKER;
                  end else if (neg_now || (low_now == '0 && !over_now)) begin
                     result.valid        = 1'b1;
                     result.frame_status = STATUS_NONPOSITIVE;
                  end else if (over_now) begin
                     result.valid        = 1'b1;
                     result.frame_status = STATUS_TOO_LARGE;
                  end else begin
                     result.result_kind = KIND_PAYLOAD;
                     remaining_in       = low_now;
                     phase_in           = PH_PAYLOAD;
                  end
               end else begin
                  pos_in      = pos_ff + POS_BITS'(1);
                  len_low_in  = low_now;
                  len_over_in = over_now;
                  len_neg_in  = neg_now;
                  fault_in    = fault_now;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HEADER;
         pos_ff       <= '0;
         len_low_ff   <= '0;
         len_over_ff  <= 1'b0;
         len_neg_ff   <= 1'b0;
         remaining_ff <= '0;
         fault_ff     <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         pos_ff       <= pos_in;
         len_low_ff   <= len_low_in;
         len_over_ff  <= len_over_in;
         len_neg_ff   <= len_neg_in;
         remaining_ff <= remaining_in;
         fault_ff     <= fault_in;
      end
   end

endmodule

### rtl/marker_length_frame_receiver.sv
// top level of the marker length frame receiver
// usage:
//   req_ch carries one received byte per item (rx_byte), valid/ready.
//   rsp_ch carries zero or one result per byte: a payload byte with its
//   last flag, or a frame status (good, bad marker, nonpositive length,
//   length too large, bad trailer).
//   a frame is an 18-byte header (5 x 0x20, 8-byte little-endian length,
//   5 x 0x21), the payload, then 5 x 0x22 and 5 x 0x23.
//   bytes go through an input register and a result register; a result
//   is registered in the result register when its byte steps the parser.
//   throughput is one byte per cycle while rsp_ch does not stall, set by the
//   combinational step of the framing state machine between the two registers.
//   while a result waits on rsp_ch, one more byte is taken into the input
//   register; after that req_ch.ready drops until the result is taken.
//   reset (synchronous) empties both registers and restarts the header hunt.
//   LENGTH_BITS sets the payload counter; longer positive lengths report too large.
module marker_length_frame_receiver
   import mlfr_pkg::*;
#(
   parameter int LENGTH_BITS = 32
) (
   input  logic      clock,
   input  logic      reset,
   mlfr_req_if.sink  req_ch,
   mlfr_rsp_if.source rsp_ch
);

   logic            in_valid_ff;
   logic [7:0]      in_byte_ff;
   logic            rsp_valid_ff;
   mlfr_result_type rsp_data_ff;
   mlfr_result_type result;
   logic            advance;
   logic            step;

   assign advance      = !rsp_valid_ff || rsp_ch.ready;
   assign step         = in_valid_ff && advance;
   assign req_ch.ready = !in_valid_ff || advance;

   mlfr_parse #(
      .LENGTH_BITS(LENGTH_BITS)
   ) u_parse (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .rx_byte (in_byte_ff),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= step && result.valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_byte_ff <= req_ch.rx_byte;
      end
      if (step && result.valid) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.result_kind  = rsp_data_ff.result_kind;
   assign rsp_ch.payload_byte = rsp_data_ff.payload_byte;
   assign rsp_ch.payload_last = rsp_data_ff.payload_last;
   assign rsp_ch.frame_status = rsp_data_ff.frame_status;

   // a held byte waits in the input register until the result side frees
   a_input_held: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_byte_ff))
      else $error("input byte lost while result stalled");

   a_status_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.result_kind == KIND_STATUS |->
         rsp_data_ff.payload_byte == 8'd0 && !rsp_data_ff.payload_last)
      else $error("status result carries payload fields");

   a_payload_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.result_kind == KIND_PAYLOAD |->
         rsp_data_ff.frame_status == STATUS_GOOD)
      else $error("payload result carries a status");

endmodule
